// File: sv/tlvd_pkg.sv
// Package: types, codes and field extraction functions for the TLV element deframer.
`default_nettype none
package tlvd_pkg;

  localparam logic [31:0] LENGTH_BYTES = 32'd4;
  localparam logic [2:0]  HEADER_LAST  = 3'd7;

  localparam logic [1:0] ORDER_BIG    = 2'd0;
  localparam logic [1:0] ORDER_LITTLE = 2'd1;
  localparam logic [1:0] ORDER_DETECT = 2'd2;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       valid;
    in_item_t   item;
  } stage_t;

  function automatic logic [7:0] hbyte(input logic [63:0] hb, input logic [2:0] idx);
    hbyte = hb[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [15:0] get16(input logic [63:0] hb, input logic [2:0] at,
                                        input logic little);
    logic [2:0] at1;
    at1 = at + 3'd1;
    if (little) begin
      get16 = {hbyte(hb, at1), hbyte(hb, at)};
    end else begin
      get16 = {hbyte(hb, at), hbyte(hb, at1)};
    end
  endfunction

  function automatic logic [31:0] get_length(input logic [63:0] hb, input logic little);
    if (little) begin
      get_length = hb[63:32];
    end else begin
      get_length = {hb[39:32], hb[47:40], hb[55:48], hb[63:56]};
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/tlvd_if.sv
// Interfaces: the byte input channel and the result channel of the deframer.
`default_nettype none
interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

interface tlvd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] tag_group;
  logic [15:0] tag_element;
  logic [31:0] value_length;
  logic [7:0]  data_byte;
  logic        last;
  logic        order_little;

  modport source (output valid, output kind, output tag_group, output tag_element,
                  output value_length, output data_byte, output last,
                  output order_little, input ready);
  modport sink   (input valid, input kind, input tag_group, input tag_element,
                  input value_length, input data_byte, input last,
                  input order_little, output ready);
endinterface
`default_nettype wire

// File: sv/tlv_element_deframer.sv
// Top level of the TLV element deframer.
// The input channel in_ch carries one stream byte or an end-of-input marker per
// transaction. Each element is an 8-byte header (group id, element id, 32-bit
// length) followed by that many value bytes. The result channel out_ch gives
// one transaction per decoded header, per value byte and per end marker; header
// bytes other than the eighth give none. A detection failure or an end marker
// inside an element gives a protocol error, after which a new header is awaited.
// The user must write the byte order register through cfg_we and cfg_wdata only
// while idle; the block does not enforce this. An accepted transaction is held in
// the input register and is then decoded into the result register, from which
// out_ch offers it. One transaction is accepted per cycle while the receiver does
// not stall; the only loop is the element state update in the decoder. When the
// receiver stalls the result register holds its transaction and the input register
// fills, after which in_ch.ready falls. Synchronous reset clears both registers,
// selects byte order detection and assumes little-endian.
`default_nettype none
module tlv_element_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tlvd_in_if.sink         in_ch,
  tlvd_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  tlvd_pkg::stage_t stage;
  logic             take;

  tlvd_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  tlvd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .take      (take),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// File: sv/tlvd_in_stage.sv
// Input register: holds one accepted transaction until the decoder takes it.
`default_nettype none
module tlvd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tlvd_in_if.sink         in_ch,
  input  wire logic       take,
  output tlvd_pkg::stage_t stage
);

  logic               valid_r;
  logic               valid_nxt;
  tlvd_pkg::in_item_t item_r;
  logic               load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.mode       <= in_ch.mode;
      item_r.byte_value <= in_ch.byte_value;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule
`default_nettype wire

// File: sv/tlvd_decode.sv
// Decoder: header assembly, byte order choice, value byte count and the result register.
`default_nettype none
module tlvd_decode (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire tlvd_pkg::stage_t stage,
  output logic             take,
  tlvd_out_if.source       out_ch
);

  logic [1:0]  order_mode_r;
  logic        in_data_r, in_data_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [63:0] hb_r, hb_nxt, hb_ins;
  logic [31:0] rem_r, rem_nxt, rem_dec, len;
  logic        little_r, little_nxt;
  logic        settled_r, settled_nxt;

  logic          res_valid;
  tlvd_pkg::kind_t res_kind;
  logic          res_fields;
  logic [7:0]    res_byte;
  logic          res_last;

  logic          out_valid_r;
  logic [1:0]    kind_r;
  logic [15:0]   group_r, element_r;
  logic [31:0]   length_r;
  logic [7:0]    byte_r;
  logic          last_r;

  logic out_free;
  logic clean;
  logic [7:0] b;

  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = stage.valid && out_free;
  assign b        = stage.item.byte_value;
  assign rem_dec  = rem_r - 32'd1;
  assign clean    = !in_data_r && (count_r == 3'd0);

  always_comb begin
    hb_ins = hb_r;
    hb_ins[{count_r, 3'b000} +: 8] = b;
  end

  always_comb begin
    in_data_nxt = in_data_r;
    count_nxt   = count_r;
    hb_nxt      = hb_r;
    rem_nxt     = rem_r;
    little_nxt  = little_r;
    settled_nxt = settled_r;
    res_valid   = 1'b0;
    res_kind    = tlvd_pkg::KIND_HEADER;
    res_fields  = 1'b0;
    res_byte    = 8'd0;
    res_last    = 1'b0;
    len         = 32'd0;
    if (stage.item.mode == tlvd_pkg::MODE_END) begin
      in_data_nxt = 1'b0;
      count_nxt   = 3'd0;
      rem_nxt     = 32'd0;
      res_valid   = 1'b1;
      res_kind    = clean ? tlvd_pkg::KIND_END : tlvd_pkg::KIND_ERROR;
    end else if (in_data_r) begin
      rem_nxt     = rem_dec;
      in_data_nxt = (rem_dec != 32'd0);
      res_valid   = 1'b1;
      res_kind    = tlvd_pkg::KIND_DATA;
      res_fields  = 1'b1;
      res_byte    = b;
      res_last    = (rem_dec == 32'd0);
    end else begin
      hb_nxt = hb_ins;
      if (count_r != tlvd_pkg::HEADER_LAST) begin
        count_nxt = count_r + 3'd1;
      end else begin
        count_nxt = 3'd0;
        res_valid = 1'b1;
        case (order_mode_r)
          tlvd_pkg::ORDER_BIG:    little_nxt = 1'b0;
          tlvd_pkg::ORDER_LITTLE: little_nxt = 1'b1;
          default: begin
            if (!settled_r) begin
              if (tlvd_pkg::get_length(hb_ins, 1'b0) == tlvd_pkg::LENGTH_BYTES) begin
                little_nxt  = 1'b0;
                settled_nxt = 1'b1;
              end else if (tlvd_pkg::get_length(hb_ins, 1'b1) == tlvd_pkg::LENGTH_BYTES) begin
                little_nxt  = 1'b1;
                settled_nxt = 1'b1;
              end else begin
                little_nxt = 1'b1;
                res_kind   = tlvd_pkg::KIND_ERROR;
              end
            end
          end
        endcase
        if (res_kind == tlvd_pkg::KIND_HEADER) begin
          len         = tlvd_pkg::get_length(hb_ins, little_nxt);
          rem_nxt     = len;
          in_data_nxt = (len != 32'd0);
          res_fields  = 1'b1;
          res_last    = (len == 32'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= tlvd_pkg::ORDER_DETECT;
      in_data_r    <= 1'b0;
      count_r      <= 3'd0;
      hb_r         <= 64'd0;
      rem_r        <= 32'd0;
      little_r     <= 1'b1;
      settled_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        in_data_r <= in_data_nxt;
        count_r   <= count_nxt;
        hb_r      <= hb_nxt;
        rem_r     <= rem_nxt;
        little_r  <= little_nxt;
      end
      if (cfg_we) begin
        order_mode_r <= cfg_wdata;
        settled_r    <= 1'b0;
      end else if (take) begin
        settled_r <= settled_nxt;
      end
      if (out_free) begin
        out_valid_r <= take && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      kind_r    <= res_kind;
      group_r   <= res_fields ? tlvd_pkg::get16(hb_nxt, 3'd0, little_nxt) : 16'd0;
      element_r <= res_fields ? tlvd_pkg::get16(hb_nxt, 3'd2, little_nxt) : 16'd0;
      length_r  <= res_fields ? tlvd_pkg::get_length(hb_nxt, little_nxt) : 32'd0;
      byte_r    <= res_byte;
      last_r    <= res_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.tag_group    = group_r;
  assign out_ch.tag_element  = element_r;
  assign out_ch.value_length = length_r;
  assign out_ch.data_byte    = byte_r;
  assign out_ch.last         = last_r;
  assign out_ch.order_little = little_r;

endmodule
`default_nettype wire

// File: tb/tlvd_checker.sv
// Checker for the TLV element deframer: watches both channels, predicts and compares results.
`timescale 1ns / 1ps
module tlvd_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tlvd_in_if              in_ch,
  tlvd_out_if             out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  output int              mismatches,
  output int              waiting,
  output int              headers_seen,
  output int              bytes_seen,
  output int              ends_seen,
  output int              errors_seen
);

  typedef struct {
    tlvd_pkg::kind_t kind;
    logic [15:0] tag_group;
    logic [15:0] tag_element;
    logic [31:0] value_length;
    logic [7:0]  data_byte;
    logic        last;
    logic        order_little;
  } deframe_result_t;

  deframe_result_t deframe_q[$];

  logic [1:0]  order_mode;
  logic        in_value;
  logic [2:0]  hdr_count;
  logic [63:0] hdr_bytes;
  logic [31:0] value_left;
  logic        little;
  logic        settled;

  function automatic logic [7:0] hdr_at(input int i);
    return hdr_bytes[8 * i +: 8];
  endfunction

  function automatic logic [15:0] id_field(input int at, input logic le);
    if (le) begin
      return {hdr_at(at + 1), hdr_at(at)};
    end
    return {hdr_at(at), hdr_at(at + 1)};
  endfunction

  function automatic logic [31:0] length_field(input logic le);
    if (le) begin
      return {hdr_at(7), hdr_at(6), hdr_at(5), hdr_at(4)};
    end
    return {hdr_at(4), hdr_at(5), hdr_at(6), hdr_at(7)};
  endfunction

  function automatic deframe_result_t result_of(input tlvd_pkg::kind_t k,
                                                input logic with_ids,
                                                input logic [7:0] d, input logic lst);
    deframe_result_t r;
    r.kind         = k;
    r.tag_group    = with_ids ? id_field(0, little) : 16'd0;
    r.tag_element  = with_ids ? id_field(2, little) : 16'd0;
    r.value_length = with_ids ? length_field(little) : 32'd0;
    r.data_byte    = d;
    r.last         = lst;
    r.order_little = little;
    return r;
  endfunction

  task automatic deframe_byte(input logic m, input logic [7:0] b);
    logic        clean;
    logic [31:0] len;
    if (m == tlvd_pkg::MODE_END) begin
      clean      = !in_value && hdr_count == 3'd0;
      in_value   = 1'b0;
      hdr_count  = 3'd0;
      value_left = 32'd0;
      deframe_q.push_back(result_of(clean ? tlvd_pkg::KIND_END : tlvd_pkg::KIND_ERROR,
                                    1'b0, 8'd0, 1'b0));
      return;
    end
    if (in_value) begin
      value_left = value_left - 32'd1;
      if (value_left == 32'd0) begin
        in_value = 1'b0;
      end
      deframe_q.push_back(result_of(tlvd_pkg::KIND_DATA, 1'b1, b, value_left == 32'd0));
      return;
    end
    hdr_bytes[8 * hdr_count +: 8] = b;
    if (hdr_count != 3'd7) begin
      hdr_count = hdr_count + 3'd1;
      return;
    end
    hdr_count = 3'd0;
    if (order_mode == tlvd_pkg::ORDER_BIG) begin
      little = 1'b0;
    end else if (order_mode == tlvd_pkg::ORDER_LITTLE) begin
      little = 1'b1;
    end else if (!settled) begin
      if (length_field(1'b0) == tlvd_pkg::LENGTH_BYTES) begin
        little  = 1'b0;
        settled = 1'b1;
      end else if (length_field(1'b1) == tlvd_pkg::LENGTH_BYTES) begin
        little  = 1'b1;
        settled = 1'b1;
      end else begin
        little = 1'b1;
        deframe_q.push_back(result_of(tlvd_pkg::KIND_ERROR, 1'b0, 8'd0, 1'b0));
        return;
      end
    end
    len        = length_field(little);
    value_left = len;
    in_value   = (len != 32'd0);
    deframe_q.push_back(result_of(tlvd_pkg::KIND_HEADER, 1'b1, 8'd0, len == 32'd0));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches   = 0;
    waiting      = 0;
    headers_seen = 0;
    bytes_seen   = 0;
    ends_seen    = 0;
    errors_seen  = 0;
  end

  always @(posedge clk) begin
    deframe_result_t want;
    if (!rst_n) begin
      order_mode = tlvd_pkg::ORDER_DETECT;
      in_value   = 1'b0;
      hdr_count  = 3'd0;
      hdr_bytes  = 64'd0;
      value_left = 32'd0;
      little     = 1'b1;
      settled    = 1'b0;
      deframe_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        case (out_ch.kind)
          tlvd_pkg::KIND_HEADER: headers_seen++;
          tlvd_pkg::KIND_DATA:   bytes_seen++;
          tlvd_pkg::KIND_END:    ends_seen++;
          default:               errors_seen++;
        endcase
        if (deframe_q.size() == 0) begin
          $display("%0t: result of kind %0d arrived, none expected", $time, out_ch.kind);
          mismatches++;
        end else begin
          want = deframe_q.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("tag_group", want.tag_group, out_ch.tag_group);
          check_field("tag_element", want.tag_element, out_ch.tag_element);
          check_field("value_length", want.value_length, out_ch.value_length);
          check_field("data_byte", want.data_byte, out_ch.data_byte);
          check_field("last", want.last, out_ch.last);
          check_field("order_little", want.order_little, out_ch.order_little);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.mode, in_ch.byte_value);
      end
      if (cfg_we) begin
        order_mode = cfg_wdata;
        settled    = 1'b0;
      end
    end
    waiting = deframe_q.size();
  end

endmodule

// File: tb/tlv_element_deframer_tb.sv
// Testbench top for the TLV element deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tlv_element_deframer_tb;

  localparam logic [1:0] ORDER_SPARE  = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  tlvd_in_if  in_ch ();
  tlvd_out_if out_ch ();

  int mismatches, waiting, n_headers, n_bytes, n_ends, n_errors;
  int sent;
  int settings;
  bit idle_on;

  logic [1:0] cur_mode;
  logic       stim_little;
  logic       stim_settled;

  tlv_element_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tlvd_checker result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .headers_seen (n_headers),
    .bytes_seen   (n_bytes),
    .ends_seen    (n_ends),
    .errors_seen  (n_errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic put_item(input logic m, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.mode       = m;
    in_ch.byte_value = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic put_header(input logic [15:0] g, input logic [15:0] e,
                            input logic [31:0] len, input logic le);
    logic [7:0] hb [8];
    if (le) begin
      hb = '{g[7:0], g[15:8], e[7:0], e[15:8], len[7:0], len[15:8], len[23:16], len[31:24]};
    end else begin
      hb = '{g[15:8], g[7:0], e[15:8], e[7:0], len[31:24], len[23:16], len[15:8], len[7:0]};
    end
    foreach (hb[i]) put_item(tlvd_pkg::MODE_DATA, hb[i]);
  endtask

  task automatic put_values(input int n);
    repeat (n) put_item(tlvd_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic set_order(input logic [1:0] m);
    in_ch.valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = m;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we       = 1'b0;
    cur_mode     = m;
    stim_settled = 1'b0;
    settings++;
  endtask

  task automatic random_element();
    int          pick;
    int          n;
    logic        le;
    logic [31:0] len;
    if (cur_mode == tlvd_pkg::ORDER_BIG) begin
      le = 1'b0;
    end else if (cur_mode == tlvd_pkg::ORDER_LITTLE) begin
      le = 1'b1;
    end else begin
      le = stim_little;
    end
    if ((cur_mode == tlvd_pkg::ORDER_DETECT || cur_mode == ORDER_SPARE) && !stim_settled) begin
      if ($urandom_range(0, 9) < 3) begin
        len = $urandom;
        if (len == 32'd4 || len == 32'h0400_0000) begin
          len = len ^ 32'h0000_0100;
        end
        put_header(16'($urandom), 16'($urandom), len, 1'($urandom));
      end else begin
        stim_little  = 1'($urandom);
        stim_settled = 1'b1;
        put_header(16'($urandom), 16'h0000, tlvd_pkg::LENGTH_BYTES, stim_little);
        put_values(tlvd_pkg::LENGTH_BYTES);
      end
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      n = $urandom_range(0, 6);
      put_header(16'($urandom), 16'($urandom), n, le);
      put_values(n);
    end else if (pick < 68) begin
      n = $urandom_range(7, 40);
      put_header(16'($urandom), 16'($urandom), n, le);
      put_values(n);
    end else if (pick < 76) begin
      put_header(16'($urandom), 16'($urandom), $urandom | 32'h100, le);
      put_values($urandom_range(0, 5));
      put_item(tlvd_pkg::MODE_END, 8'($urandom));
    end else if (pick < 84) begin
      put_values($urandom_range(1, 7));
      put_item(tlvd_pkg::MODE_END, 8'($urandom));
    end else if (pick < 92) begin
      put_item(tlvd_pkg::MODE_END, 8'($urandom));
    end else begin
      n = $urandom_range(1, 6);
      put_header(16'($urandom), 16'($urandom), n, le);
      put_values($urandom_range(0, n - 1));
      put_item(tlvd_pkg::MODE_END, 8'($urandom));
    end
  endtask

  initial begin
    int         phase_stop;
    int         guard;
    logic [1:0] phase_modes [8];
    phase_modes = '{tlvd_pkg::ORDER_DETECT, tlvd_pkg::ORDER_BIG, tlvd_pkg::ORDER_LITTLE,
                    ORDER_SPARE, tlvd_pkg::ORDER_DETECT, tlvd_pkg::ORDER_BIG,
                    tlvd_pkg::ORDER_DETECT, tlvd_pkg::ORDER_LITTLE};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = tlvd_pkg::MODE_DATA;
    in_ch.byte_value = 8'd0;
    cfg_we           = 1'b0;
    cfg_wdata        = 2'd0;
    sent             = 0;
    settings         = 0;
    idle_on          = 1'b1;
    cur_mode         = tlvd_pkg::ORDER_DETECT;
    stim_little      = 1'b1;
    stim_settled     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    put_item(tlvd_pkg::MODE_END, 8'hff);
    put_header(16'h0008, 16'h0000, tlvd_pkg::LENGTH_BYTES, 1'b0);
    put_item(tlvd_pkg::MODE_DATA, 8'hff);
    put_item(tlvd_pkg::MODE_END, 8'h00);
    set_order(tlvd_pkg::ORDER_BIG);
    put_header(16'hffff, 16'hffff, 32'd0, 1'b0);
    set_order(tlvd_pkg::ORDER_DETECT);
    put_header(16'h0000, 16'h0000, 32'hffff_ffff, 1'b1);

    phase_stop = sent + 110;
    for (int p = 0; p < 8; p++) begin
      idle_on = (p < 7);
      set_order(phase_modes[p]);
      while (sent < phase_stop) random_element();
      phase_stop += 110;
    end

    in_ch.valid = 1'b0;
    guard = 0;
    while (waiting != 0 && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (waiting != 0) begin
      $display("%0t: %0d expected results never arrived", $time, waiting);
    end
    $display("Run covered %0d input transactions under %0d byte order settings.",
             sent, settings);
    $display("Results seen: %0d headers, %0d value bytes, %0d clean ends, %0d errors.",
             n_headers, n_bytes, n_ends, n_errors);
    if (mismatches == 0 && waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
